// ----- design/cce_pkg.sv -----
// ---------------------------------------------------------------------------
// cce_pkg: configurable CRC engine package
// Shared types, register indexes, width codes and reset values.
// ---------------------------------------------------------------------------
package cce_pkg;

  localparam int unsigned CRC_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFLECTED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_XOR_OUT   = 3'd4;

  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  localparam logic [CRC_W-1:0] POLY_RST = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] INIT_RST = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] XOR_RST  = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_RST  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]       width_sel;
    logic             reflected;
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] init_value;
    logic [CRC_W-1:0] xor_out;
  } cfg_t;

  function automatic logic [CRC_W-1:0] width_mask(input logic [1:0] wsel);
    logic [CRC_W-1:0] m;
    case (wsel)
      WSEL_8:  m = 32'h0000_00FF;
      WSEL_16: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ----- design/cce_in_if.sv -----
// ---------------------------------------------------------------------------
// cce_in_if: request channel
// Valid/ready channel carrying a command and a data byte.
// ---------------------------------------------------------------------------
interface cce_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ----- design/cce_out_if.sv -----
// ---------------------------------------------------------------------------
// cce_out_if: result channel
// Valid/ready channel carrying the reported checksum.
// ---------------------------------------------------------------------------
interface cce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

// ----- design/configurable_crc_engine_top.sv -----
// ---------------------------------------------------------------------------
// configurable_crc_engine_top: byte-wise CRC engine, 8/16/32 bits
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    command, data_byte
//   out_ch    out  valid/ready    checksum
//   cfg_*     in   write enable   cfg_index, cfg_wdata
//
// A request is registered, then folded into the CRC register when that
// stage advances, as its checksum lands in the output register. One request
// per cycle sustained unless out_ch stalls; the byte step is combinational.
// Reset is synchronous; the CRC register resets to all ones.
// A stalled output holds the input stage; in_ch.ready drops only when both
// stages are full and out_ch.ready is low.
// ---------------------------------------------------------------------------
module configurable_crc_engine_top (
  input  logic                          clk,
  input  logic                          rst_n,
  cce_in_if.sink                        in_ch,
  cce_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [cce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cce_pkg::CRC_W-1:0]     cfg_wdata
);
  import cce_pkg::*;

  cfg_t             cfg;
  logic             s1_valid_r;
  logic             s1_cmd_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic             out_valid_r;
  logic [CRC_W-1:0] out_sum_r;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic [CRC_W-1:0] sum_nxt;
  logic             s1_adv;
  logic             in_take;

  cce_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cce_dp u_dp (
    .cfg       (cfg),
    .crc       (crc_r),
    .command   (s1_cmd_r),
    .data_byte (s1_byte_r),
    .crc_nxt   (crc_nxt),
    .checksum  (sum_nxt)
  );

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= CRC_RST;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        crc_r       <= crc_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_ch.command;
      s1_byte_r <= in_ch.data_byte;
    end
    if (s1_adv) begin
      out_sum_r <= sum_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.checksum = out_sum_r;

endmodule

// ----- design/cce_cfg.sv -----
// ---------------------------------------------------------------------------
// cce_cfg: configuration registers
// Write-only register file for width, bit order, polynomial, init and xor.
// ---------------------------------------------------------------------------
module cce_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cce_pkg::CRC_W-1:0]      cfg_wdata,
  output cce_pkg::cfg_t                  cfg
);
  import cce_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_SEL: cfg_nxt.width_sel  = cfg_wdata[1:0];
        REG_REFLECTED: cfg_nxt.reflected  = cfg_wdata[0];
        REG_POLY:      cfg_nxt.polynomial = cfg_wdata;
        REG_INIT:      cfg_nxt.init_value = cfg_wdata;
        REG_XOR_OUT:   cfg_nxt.xor_out    = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_sel  <= WSEL_32;
      cfg_r.reflected  <= 1'b1;
      cfg_r.polynomial <= POLY_RST;
      cfg_r.init_value <= INIT_RST;
      cfg_r.xor_out    <= XOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/cce_dp.sv -----
// ---------------------------------------------------------------------------
// cce_dp: CRC byte step
// Folds a byte into the CRC or, on restart, loads init; 8/16-bit widths run
// top-aligned in the 32-bit path for MSB-first, low-aligned for LSB-first.
// ---------------------------------------------------------------------------
module cce_dp (
  input  cce_pkg::cfg_t              cfg,
  input  logic [cce_pkg::CRC_W-1:0]  crc,
  input  logic                       command,
  input  logic [cce_pkg::BYTE_W-1:0] data_byte,
  output logic [cce_pkg::CRC_W-1:0]  crc_nxt,
  output logic [cce_pkg::CRC_W-1:0]  checksum
);
  import cce_pkg::*;

  logic [CRC_W-1:0] mask;
  logic [CRC_W-1:0] crc_m;
  logic [CRC_W-1:0] poly_al;
  logic [CRC_W-1:0] poly_rev;
  logic [CRC_W-1:0] crc_al;
  logic [CRC_W-1:0] c_lsb;
  logic [CRC_W-1:0] c_msb;
  logic [CRC_W-1:0] v_lsb;
  logic [CRC_W-1:0] v_msb;
  logic [CRC_W-1:0] res_lsb;
  logic [CRC_W-1:0] res_msb_al;
  logic [CRC_W-1:0] res_msb;

  assign mask  = width_mask(cfg.width_sel);
  assign crc_m = crc & mask;

  always_comb begin
    case (cfg.width_sel)
      WSEL_8: begin
        poly_al = {cfg.polynomial[7:0], 24'b0};
        crc_al  = {crc_m[7:0], 24'b0};
      end
      WSEL_16: begin
        poly_al = {cfg.polynomial[15:0], 16'b0};
        crc_al  = {crc_m[15:0], 16'b0};
      end
      default: begin
        poly_al = cfg.polynomial;
        crc_al  = crc_m;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < CRC_W; i++) begin
      poly_rev[i] = poly_al[CRC_W-1-i];
    end
  end

  always_comb begin
    c_lsb = crc_m ^ {24'b0, data_byte};
    v_lsb = {24'b0, c_lsb[7:0]};
    for (int i = 0; i < BYTE_W; i++) begin
      v_lsb = v_lsb[0] ? ((v_lsb >> 1) ^ poly_rev) : (v_lsb >> 1);
    end
    res_lsb = (v_lsb ^ (c_lsb >> 8)) & mask;
  end

  always_comb begin
    c_msb = crc_al ^ {data_byte, 24'b0};
    v_msb = {c_msb[31:24], 24'b0};
    for (int i = 0; i < BYTE_W; i++) begin
      v_msb = v_msb[CRC_W-1] ? ((v_msb << 1) ^ poly_al) : (v_msb << 1);
    end
    res_msb_al = v_msb ^ (c_msb << 8);
  end

  always_comb begin
    case (cfg.width_sel)
      WSEL_8:  res_msb = {24'b0, res_msb_al[31:24]};
      WSEL_16: res_msb = {16'b0, res_msb_al[31:16]};
      default: res_msb = res_msb_al;
    endcase
  end

  always_comb begin
    if (command == CMD_RESTART) begin
      crc_nxt = cfg.init_value & mask;
    end else if (cfg.reflected) begin
      crc_nxt = res_lsb;
    end else begin
      crc_nxt = res_msb;
    end
  end

  assign checksum = (crc_nxt ^ cfg.xor_out) & mask;

endmodule

// ----- verif/configurable_crc_engine_top_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// configurable_crc_engine_top_test: checksum checks for the CRC engine
// Drives restart and data requests through the valid/ready request channel
// and reprograms width, bit order, polynomial, initial value and output XOR
// between phases. A local CRC predictor runs on every accepted request, and
// each returned checksum is compared in order against the predicted one.
// Random idle bursts on both channels, one long output hold-off, and a
// final stretch at full rate.
// ---------------------------------------------------------------------------
module configurable_crc_engine_top_test;
  import cce_pkg::*;

  localparam logic [1:0]           WSEL_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_XOR_OUT + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;
  localparam int                   LONG_HOLD     = 240;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CRC_W-1:0] cfg_wdata = '0;

  cce_in_if  in_ch ();
  cce_out_if out_ch ();

  configurable_crc_engine_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t cur_cfg = '{width_sel: WSEL_32, reflected: 1'b1, polynomial: POLY_RST,
                    init_value: INIT_RST, xor_out: XOR_RST};
  logic [CRC_W-1:0] crc_state = CRC_RST;
  logic [CRC_W-1:0] pending_sums[$];

  int errors = 0;
  int requests_seen = 0;
  int sums_checked = 0;
  int settings_used = 1;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_off_req = 1'b0;

  always #5 clk = ~clk;

  function automatic logic [CRC_W-1:0] next_checksum(input logic cmd, input logic [7:0] b);
    int unsigned w;
    logic [CRC_W-1:0] m, p, c, v;
    w = (cur_cfg.width_sel == WSEL_8) ? 8 : (cur_cfg.width_sel == WSEL_16) ? 16 : 32;
    m = (w == 32) ? '1 : ((32'd1 << w) - 32'd1);
    p = '0;
    if (cur_cfg.reflected) begin
      for (int i = 0; i < w; i++) p[i] = cur_cfg.polynomial[w-1-i];
    end else begin
      p = cur_cfg.polynomial & m;
    end
    c = crc_state & m;
    if (cmd == CMD_RESTART) begin
      c = cur_cfg.init_value & m;
    end else if (cur_cfg.reflected) begin
      c = c ^ {24'b0, b};
      v = c & 32'hFF;
      repeat (8) v = v[0] ? ((v >> 1) ^ p) : (v >> 1);
      c = (v & m) ^ (c >> 8);
    end else begin
      c = c ^ ({24'b0, b} << (w - 8));
      v = ((c >> (w - 8)) & 32'hFF) << (w - 8);
      repeat (8) v = v[w-1] ? ((v << 1) ^ p) : (v << 1);
      c = (v & m) ^ ((c << 8) & m);
    end
    crc_state = c & m;
    return (crc_state ^ cur_cfg.xor_out) & m;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected checksum, expected none, actual %h", $time,
                   out_ch.checksum);
          errors++;
        end else begin
          logic [CRC_W-1:0] want;
          want = pending_sums.pop_front();
          sums_checked++;
          if (out_ch.checksum !== want) begin
            $display("%0t: checksum mismatch, expected %h, actual %h", $time, want,
                     out_ch.checksum);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_sums.push_back(next_checksum(in_ch.command, in_ch.data_byte));
        requests_seen++;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic cmd, input logic [7:0] b);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [1:0] ws, input logic refl,
                              input logic [CRC_W-1:0] poly, input logic [CRC_W-1:0] init,
                              input logic [CRC_W-1:0] xo);
    settle();
    cfg_write(REG_WIDTH_SEL, ($urandom() & ~32'h3) | {30'b0, ws});
    cfg_write(REG_REFLECTED, ($urandom() & ~32'h1) | {31'b0, refl});
    cfg_write(REG_POLY, poly);
    cfg_write(REG_INIT, init);
    cfg_write(REG_XOR_OUT, xo);
    cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom());
    cfg_we <= 1'b0;
    cur_cfg = '{width_sel: ws, reflected: refl, polynomial: poly, init_value: init,
                xor_out: xo};
    settings_used++;
  endtask

  function automatic logic [CRC_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return POLY_RST;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_message(input int len);
    send_request(CMD_RESTART, 8'($urandom_range(0, 255)));
    repeat (len) begin
      if ($urandom_range(0, 19) == 0) send_request(CMD_RESTART, 8'($urandom_range(0, 255)));
      else send_request(CMD_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_reset_state();
    send_request(CMD_DATA, 8'hFF);
    send_request(CMD_DATA, 8'h00);
    send_request(CMD_RESTART, 8'hFF);
    send_request(CMD_DATA, 8'h31);
    settle();
  endtask

  task automatic test_directed();
    apply_config(WSEL_8, 1'b0, 32'h0000_0007, 32'h0, 32'h0);
    send_request(CMD_RESTART, 8'hA5);
    send_request(CMD_DATA, 8'hFF);
    send_request(CMD_DATA, 8'h80);
    send_request(CMD_DATA, 8'h01);
    apply_config(WSEL_16, 1'b1, 32'h0000_8005, 32'hFFFF_FFFF, 32'h0);
    send_request(CMD_RESTART, 8'h00);
    send_request(CMD_DATA, 8'hAA);
    send_request(CMD_DATA, 8'h55);
    apply_config(WSEL_UNUSED, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_RESTART, 8'h5A);
    send_request(CMD_DATA, 8'h00);
    send_request(CMD_DATA, 8'hFF);
    apply_config(WSEL_32, 1'b1, 32'h0, 32'h0, 32'h0);
    send_request(CMD_RESTART, 8'hFF);
    send_request(CMD_DATA, 8'hFF);
    settle();
  endtask

  task automatic test_width_change();
    apply_config(WSEL_32, 1'b1, POLY_RST, INIT_RST, XOR_RST);
    send_request(CMD_RESTART, 8'h00);
    send_request(CMD_DATA, 8'h12);
    send_request(CMD_DATA, 8'h34);
    apply_config(WSEL_8, 1'b1, 32'h0000_0031, 32'h0, 32'h0000_00FF);
    send_request(CMD_DATA, 8'h56);
    apply_config(WSEL_16, 1'b0, 32'h0000_1021, 32'h0, 32'h0);
    send_request(CMD_DATA, 8'h78);
    apply_config(WSEL_32, 1'b0, 32'h1EDC_6F41, 32'h0, 32'h0);
    send_request(CMD_DATA, 8'h9A);
    settle();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      int start;
      start = requests_seen;
      apply_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_word(),
                   pick_word(), pick_word());
      while (requests_seen - start < 55) send_message($urandom_range(1, 16));
    end
    settle();
  endtask

  task automatic test_output_hold_off();
    apply_config(WSEL_16, 1'b1, 32'h0000_8005, 32'h0, 32'hFFFF_FFFF);
    src_idle_on = 1'b0;
    hold_off_req = 1'b1;
    send_message(39);
    src_idle_on = 1'b1;
    settle();
  endtask

  task automatic test_full_rate();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    apply_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pick_word(),
                 pick_word(), pick_word());
    repeat (4) send_message($urandom_range(8, 16));
    settle();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_RESTART;
    in_ch.data_byte = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_width_change();
    test_random_phases();
    test_output_hold_off();
    test_full_rate();
    repeat (10) @(posedge clk);
    $display("covered %0d requests, %0d checksums checked, %0d register settings",
             requests_seen, sums_checked, settings_used);
    $display("widths 8/16/32 and the unused code, both bit orders, stalls on both sides");
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("configurable_crc_engine_top_test: done, clean");
    end else begin
      $display("configurable_crc_engine_top_test: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d checksums outstanding", pending_sums.size());
    $display("configurable_crc_engine_top_test: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
design/cce_pkg.sv
design/cce_in_if.sv
design/cce_out_if.sv
design/cce_cfg.sv
design/cce_dp.sv
design/configurable_crc_engine_top.sv
verif/configurable_crc_engine_top_test.sv
